// ===== rtl/itoar_pkg.sv =====
// itoar_pkg: shared constants and the digit-to-character function
// for the integer_to_ascii_radix block; no dependencies
`default_nettype none

package itoar_pkg;

	localparam int VALUE_BITS_DEF = 32;
	localparam int RADIX_W        = 6;
	localparam int CHAR_W         = 8;

	localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
	localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
	localparam logic [RADIX_W-1:0] RADIX_TEN   = 6'd10;
	localparam logic [RADIX_W-1:0] DIGIT_NINE  = 6'd9;

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
	// 'a' minus ten, so digit ten maps to 'a'
	localparam logic [CHAR_W-1:0] CHAR_ALPHA = 8'h57;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;

	function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
		logic [CHAR_W-1:0] dw;
		dw = {{(CHAR_W-RADIX_W){1'b0}}, d};
		if (d > DIGIT_NINE) begin
			digit_char = dw + CHAR_ALPHA;
		end else begin
			digit_char = dw + CHAR_ZERO;
		end
	endfunction

endpackage

`default_nettype wire

// ===== rtl/integer_to_ascii_radix.sv =====
// integer_to_ascii_radix: converts one signed integer to text in a
// configurable base, one character per output transaction
// uses itoar_pkg and itoar_divider
//
// usage:
//   cfg channel (cfg_valid/cfg_ready, always ready) writes the 6-bit radix;
//   values below 2 act as 2, above 36 act as 36; reset value is 10.
//   write it only while the block is idle.
//   input channel (in_valid/in_stall) takes one number per transaction;
//   in_stall stays high from acceptance until the last character is taken.
//   output channel (out_valid/out_stall) gives characters most significant
//   first, final_char marks the last one; base ten shows a leading '-' for a negative value.
// sequencing:
//   each digit costs one pass of the shared bit-serial divider, and each
//   character is then emitted through the read, load and wait states.
//   a stall on the output holds the current character and the sequencer.
//   reset returns the sequencer to idle and the radix to ten.
`default_nettype none

module integer_to_ascii_radix
	import itoar_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [RADIX_W-1:0]           cfg_data,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic signed [VALUE_BITS-1:0] number,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [CHAR_W-1:0]                 character,
	output logic                              final_char
);

	localparam int AW = $clog2(VALUE_BITS + 1);
	localparam int NW = $clog2(VALUE_BITS + 2);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_START = 3'd1;
	localparam logic [2:0] ST_DIV   = 3'd2;
	localparam logic [2:0] ST_SIGN  = 3'd3;
	localparam logic [2:0] ST_READ  = 3'd4;
	localparam logic [2:0] ST_LOAD  = 3'd5;
	localparam logic [2:0] ST_WAIT  = 3'd6;

	logic [2:0]            state_q;
	logic [RADIX_W-1:0]    radix_q;
	logic [RADIX_W-1:0]    base_q;
	logic                  neg_q;
	logic [VALUE_BITS-1:0] mag_q;
	logic [NW-1:0]         ndig_q;
	logic [AW-1:0]         rd_idx_q;
	logic                  out_valid_q;
	logic [CHAR_W-1:0]     char_q;
	logic                  final_q;

	logic [CHAR_W-1:0] mem [0:VALUE_BITS];
	logic [CHAR_W-1:0] rd_data_q;

	logic [RADIX_W-1:0]    base_d;
	logic                  neg_d;
	logic [VALUE_BITS-1:0] num_u;
	logic                  in_acc;
	logic                  out_acc;
	logic                  div_start;
	logic                  div_done;
	logic [VALUE_BITS-1:0] div_quo;
	logic [RADIX_W-1:0]    div_rem;
	logic                  mem_we;
	logic [CHAR_W-1:0]     mem_wdata;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_acc   = out_valid_q && !out_stall;
	assign num_u     = VALUE_BITS'(number);

	always_comb begin
		base_d = radix_q;
		if (radix_q < RADIX_MIN) begin
			base_d = RADIX_MIN;
		end else if (radix_q > RADIX_MAX) begin
			base_d = RADIX_MAX;
		end
		neg_d = (base_d == RADIX_TEN) && num_u[VALUE_BITS-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (cfg_valid && cfg_ready) begin
			radix_q <= cfg_data;
		end
	end

	assign div_start = (state_q == ST_START);

	itoar_divider #(
		.VALUE_BITS(VALUE_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mag_q),
		.divisor  (base_q),
		.done     (div_done),
		.quotient (div_quo),
		.remainder(div_rem)
	);

	always_comb begin
		mem_we    = 1'b0;
		mem_wdata = digit_char(div_rem);
		if (state_q == ST_DIV && div_done) begin
			mem_we = 1'b1;
		end else if (state_q == ST_SIGN) begin
			mem_we    = 1'b1;
			mem_wdata = CHAR_MINUS;
		end
	end

	// character stack, written least significant first
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[ndig_q[AW-1:0]] <= mem_wdata;
		end
		rd_data_q <= mem[rd_idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ndig_q      <= '0;
			rd_idx_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						ndig_q  <= '0;
						state_q <= ST_START;
					end
				end
				ST_START: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						ndig_q <= ndig_q + 1'b1;
						if (div_quo != '0) begin
							state_q <= ST_START;
						end else if (neg_q) begin
							state_q <= ST_SIGN;
						end else begin
							rd_idx_q <= ndig_q[AW-1:0];
							state_q  <= ST_READ;
						end
					end
				end
				ST_SIGN: begin
					ndig_q   <= ndig_q + 1'b1;
					rd_idx_q <= ndig_q[AW-1:0];
					state_q  <= ST_READ;
				end
				ST_READ: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					out_valid_q <= 1'b1;
					state_q     <= ST_WAIT;
				end
				ST_WAIT: begin
					if (out_acc) begin
						out_valid_q <= 1'b0;
						if (final_q) begin
							state_q <= ST_IDLE;
						end else begin
							rd_idx_q <= rd_idx_q - 1'b1;
							state_q  <= ST_READ;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			base_q <= base_d;
			neg_q  <= neg_d;
			// the most negative value wraps to itself, correct as unsigned
			mag_q  <= neg_d ? (~num_u + VALUE_BITS'(1)) : num_u;
		end else if (state_q == ST_DIV && div_done) begin
			mag_q <= div_quo;
		end
		if (state_q == ST_LOAD) begin
			char_q  <= rd_data_q;
			final_q <= (rd_idx_q == '0);
		end
	end

	assign out_valid  = out_valid_q;
	assign character  = char_q;
	assign final_char = final_q;

	a_no_input_while_output: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !out_valid)
		else $error("input ready while a character is pending");

	a_idle_after_final: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && final_char |=> !in_stall && !out_valid)
		else $error("sequencer not idle after the final character");

	a_done_only_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider finished outside the divide state");

	a_digit_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ndig_q <= NW'(VALUE_BITS + 1))
		else $error("digit count beyond the character store");

endmodule

`default_nettype wire

// ===== rtl/itoar_divider.sv =====
// itoar_divider: restoring divider, one quotient bit per cycle,
// value by a 6-bit base; uses itoar_pkg
`default_nettype none

module itoar_divider
	import itoar_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [VALUE_BITS-1:0] dividend,
	input  wire logic [RADIX_W-1:0]    divisor,
	output logic                       done,
	output logic [VALUE_BITS-1:0]      quotient,
	output logic [RADIX_W-1:0]         remainder
);

	localparam int CW = $clog2(VALUE_BITS + 1);

	logic [VALUE_BITS-1:0] quo_q;
	logic [RADIX_W-1:0]    rem_q;
	logic [RADIX_W-1:0]    div_q;
	logic [CW-1:0]         cnt_q;
	logic                  busy_q;
	logic                  done_q;

	logic [RADIX_W:0] trial;
	logic [RADIX_W:0] diff;
	logic             ge;

	assign trial = {rem_q, quo_q[VALUE_BITS-1]};
	assign diff  = trial - {1'b0, div_q};
	assign ge    = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(VALUE_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[VALUE_BITS-2:0], ge};
			// remainder stays below the base, so it fits in RADIX_W bits
			rem_q <= ge ? diff[RADIX_W-1:0] : trial[RADIX_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire
